>>> sv/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg: shared types and constants of the block cache
// Item structs, codes, cell control and search packet types.
// ----------------------------------------------------------------------------
`default_nettype none

package bcm_pkg;

    localparam int SLOT_W = 12;
    localparam int CNT_W  = 13;
    localparam int CFG_DATA_W = 9;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_INSERT = 2'd2;
    localparam logic [1:0] REQ_BAD    = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_REJ  = 2'd3;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_IN_USE = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [4:0]  disk_id;
        logic [8:0]  block_id;
        logic [4:0]  word_index;
        logic [63:0] data_word;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] data_word_res;
        logic        last;
        logic [31:0] hit_count;
        logic [31:0] query_count;
    } res_t;

    typedef struct packed {
        logic              clear;
        logic              trim;
        logic [CNT_W-1:0]  in_use;
        logic              wr;
        logic              wr_tag;
        logic [SLOT_W-1:0] wr_slot;
        logic [4:0]        wr_disk;
        logic [8:0]        wr_block;
        logic [31:0]       wr_stamp;
    } ctrl_t;

    typedef struct packed {
        logic              busy;
        logic [4:0]        disk;
        logic [8:0]        block;
        logic              mfound;
        logic [SLOT_W-1:0] midx;
        logic              vfound;
        logic              vstop;
        logic [SLOT_W-1:0] vidx;
        logic [31:0]       best;
    } pkt_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

>>> sv/block_cache_mru.sv
// ----------------------------------------------------------------------------
// block_cache_mru: fully associative block cache, MRU replacement
// Tags live in a row of cells searched by a travelling packet.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: lookup, update or insert items (valid/ready).
//   res channel: result items with status, data and saturating counters.
//   cfg channel: index 0 enable (clears the cache), index 1 slots in use.
// Operation: a lookup, or word 0 of an update or insert, searches all
//   ENTRIES cells, one per cycle, and then gives a single result, or the
//   first word of a lookup hit.
//   A lookup hit then streams BLOCK_WORDS words through the single
//   registered read port of the block store, each read in S_RD, sent in S_EMIT.
//   Later words of an update or insert are written without a search.
//   Bad word indices give no result.
// Reset: cache disabled, all entries invalid, counters zero, slots in use
//   ENTRIES. The block store is not cleared.
// Stall: a result item is held in the output register until taken; the
//   block then waits before loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module block_cache_mru
    import bcm_pkg::*;
#(
    parameter int ENTRIES         = 256,
    parameter int BLOCK_WORDS     = 32,
    parameter int DISKS           = 16,
    parameter int BLOCKS_PER_DISK = 256
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire req_t                  req,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output res_t                       res,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW     = $clog2(ENTRIES);
    localparam int IU_W   = $clog2(ENTRIES + 1);
    localparam int MEM_D  = ENTRIES * BLOCK_WORDS;
    localparam int ADDR_W = $clog2(MEM_D);
    localparam int WC_W   = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESP,
        S_RD,
        S_EMIT
    } state_t;

    state_t            state_reg;
    logic              enable_reg;
    logic [IU_W-1:0]   in_use_reg;
    logic [31:0]       clock_reg;
    logic [31:0]       hits_reg;
    logic [31:0]       queries_reg;
    logic [SW-1:0]     pend_slot_reg;
    logic              pend_reg;
    logic [1:0]        op_reg;
    logic [4:0]        disk_reg;
    logic [8:0]        block_reg;
    logic [63:0]       word0_reg;
    logic [1:0]        status_reg;
    logic [SW-1:0]     slot_reg;
    logic [WC_W-1:0]   cnt_reg;
    logic              res_valid_reg;
    res_t              res_reg;

    logic [63:0]       mem [MEM_D];
    logic [63:0]       mem_q;

    logic              acc_req;
    logic              acc_cfg;
    logic              widx_ok;
    logic              widx_zero;
    logic              in_range;
    logic              cfg_ok;
    logic              scan_done;
    logic              hit;
    logic              do_write;
    logic              strm_write;
    logic [SW-1:0]     midx;
    logic [SW-1:0]     vidx;
    logic [SW-1:0]     wslot;
    logic [31:0]       new_clock;
    logic              out_free;
    logic              res_load;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [63:0]       mem_wd;
    logic [ADDR_W-1:0] mem_ra;
    ctrl_t             ctrl;
    pkt_t              pkt_in;
    pkt_t              pkt_out;

    bcm_chain #(
        .ENTRIES (ENTRIES)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .pkt_in  (pkt_in),
        .pkt_out (pkt_out)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign req_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign acc_req   = req_valid && req_ready;
    assign acc_cfg   = cfg_valid && cfg_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || res_ready;
    assign res_load  = out_free && ((state_reg == S_RESP) || (state_reg == S_EMIT));

    assign widx_ok   = 32'(req.word_index) < BLOCK_WORDS;
    assign widx_zero = (req.word_index == 5'd0);
    assign in_range  = (32'(req.disk_id) < DISKS) && (32'(req.block_id) < BLOCKS_PER_DISK);
    assign cfg_ok    = (cfg_data >= CFG_DATA_W'(2)) && (32'(cfg_data) <= ENTRIES);

    assign scan_done = (state_reg == S_SCAN) && pkt_out.busy;
    assign hit       = pkt_out.mfound;
    assign midx      = pkt_out.midx[SW-1:0];
    assign vidx      = pkt_out.vidx[SW-1:0];
    assign wslot     = (op_reg == REQ_UPDATE) ? midx : vidx;
    assign new_clock = sat_inc(clock_reg);
    assign do_write  = scan_done &&
                       (((op_reg == REQ_UPDATE) && hit) ||
                        ((op_reg == REQ_INSERT) && !hit && pkt_out.vfound));
    assign strm_write = acc_req && (req.req_type == REQ_UPDATE ||
                        req.req_type == REQ_INSERT) && widx_ok && !widx_zero && pend_reg;

    always_comb
    begin
        pkt_in       = '0;
        pkt_in.disk  = req.disk_id;
        pkt_in.block = req.block_id;
        pkt_in.busy  = acc_req && enable_reg &&
                       ((req.req_type == REQ_LOOKUP) ||
                        (widx_ok && widx_zero &&
                         ((req.req_type == REQ_UPDATE) ||
                          (req.req_type == REQ_INSERT && in_range))));

        ctrl          = '0;
        ctrl.clear    = acc_cfg && (cfg_index == CFG_ENABLE);
        ctrl.trim     = acc_cfg && (cfg_index == CFG_IN_USE) && cfg_ok;
        ctrl.in_use   = ctrl.trim ? CNT_W'(cfg_data) : CNT_W'(in_use_reg);
        ctrl.wr       = do_write || (scan_done && (op_reg == REQ_LOOKUP) && hit);
        ctrl.wr_tag   = do_write && (op_reg == REQ_INSERT);
        ctrl.wr_slot  = SLOT_W'((op_reg == REQ_LOOKUP) ? midx : wslot);
        ctrl.wr_disk  = disk_reg;
        ctrl.wr_block = block_reg;
        ctrl.wr_stamp = new_clock;

        mem_we = do_write || strm_write;
        if (do_write)
        begin
            mem_wa = ADDR_W'(wslot) * ADDR_W'(BLOCK_WORDS);
            mem_wd = word0_reg;
        end
        else
        begin
            mem_wa = ADDR_W'(pend_slot_reg) * ADDR_W'(BLOCK_WORDS) +
                     ADDR_W'(req.word_index);
            mem_wd = req.data_word;
        end
        mem_ra = ADDR_W'(slot_reg) * ADDR_W'(BLOCK_WORDS) + ADDR_W'(cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (state_reg == S_RD)
        begin
            mem_q <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            in_use_reg    <= IU_W'(ENTRIES);
            clock_reg     <= '0;
            hits_reg      <= '0;
            queries_reg   <= '0;
            pend_slot_reg <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            op_reg        <= REQ_LOOKUP;
            status_reg    <= ST_OK;
            slot_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready && !res_load)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc_cfg)
                    begin
                        if (cfg_index == CFG_ENABLE)
                        begin
                            enable_reg    <= cfg_data[0];
                            clock_reg     <= '0;
                            hits_reg      <= '0;
                            queries_reg   <= '0;
                            pend_slot_reg <= '0;
                            pend_reg      <= 1'b0;
                        end
                        else if (cfg_ok)
                        begin
                            in_use_reg <= IU_W'(cfg_data);
                            pend_reg   <= 1'b0;
                        end
                    end
                    if (acc_req)
                    begin
                        op_reg    <= req.req_type;
                        disk_reg  <= req.disk_id;
                        block_reg <= req.block_id;
                        word0_reg <= req.data_word;
                        case (req.req_type)
                            REQ_LOOKUP:
                            begin
                                pend_reg <= 1'b0;
                                if (enable_reg)
                                begin
                                    queries_reg <= sat_inc(queries_reg);
                                    state_reg   <= S_SCAN;
                                end
                                else
                                begin
                                    status_reg <= ST_MISS;
                                    state_reg  <= S_RESP;
                                end
                            end
                            REQ_BAD:
                            begin
                                status_reg <= ST_REJ;
                                state_reg  <= S_RESP;
                            end
                            default:
                            begin
                                if (widx_ok && !widx_zero)
                                begin
                                    if (pend_reg &&
                                        32'(req.word_index) == BLOCK_WORDS - 1)
                                    begin
                                        pend_reg <= 1'b0;
                                    end
                                end
                                else if (widx_ok)
                                begin
                                    pend_reg <= 1'b0;
                                    if (pkt_in.busy)
                                    begin
                                        state_reg <= S_SCAN;
                                    end
                                    else
                                    begin
                                        status_reg <= (req.req_type == REQ_UPDATE) ?
                                                      ST_MISS : ST_REJ;
                                        state_reg  <= S_RESP;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (scan_done)
                    begin
                        state_reg <= ((op_reg == REQ_LOOKUP) && hit) ? S_RD : S_RESP;
                        if (ctrl.wr)
                        begin
                            clock_reg <= new_clock;
                        end
                        if (do_write)
                        begin
                            pend_slot_reg <= wslot;
                            pend_reg      <= (BLOCK_WORDS > 1);
                        end
                        case (op_reg)
                            REQ_LOOKUP:
                            begin
                                if (hit)
                                begin
                                    hits_reg  <= sat_inc(hits_reg);
                                    slot_reg  <= midx;
                                    cnt_reg   <= '0;
                                end
                                else
                                begin
                                    status_reg <= ST_MISS;
                                end
                            end
                            REQ_UPDATE:
                            begin
                                status_reg <= hit ? ST_OK : ST_MISS;
                            end
                            default:
                            begin
                                if (hit)
                                begin
                                    status_reg <= ST_DUP;
                                end
                                else
                                begin
                                    status_reg <= pkt_out.vfound ? ST_OK : ST_REJ;
                                end
                            end
                        endcase
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        res_valid_reg         <= 1'b1;
                        res_reg.status        <= status_reg;
                        res_reg.data_word_res <= '0;
                        res_reg.last          <= 1'b1;
                        res_reg.hit_count     <= hits_reg;
                        res_reg.query_count   <= queries_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg         <= 1'b1;
                        res_reg.status        <= ST_OK;
                        res_reg.data_word_res <= mem_q;
                        res_reg.last          <= (32'(cnt_reg) == BLOCK_WORDS - 1);
                        res_reg.hit_count     <= hits_reg;
                        res_reg.query_count   <= queries_reg;
                        cnt_reg               <= cnt_reg + WC_W'(1);
                        state_reg             <= (32'(cnt_reg) == BLOCK_WORDS - 1) ?
                                                 S_IDLE : S_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_out.busy |-> state_reg == S_SCAN)
        else $error("search packet left the chain outside a scan");

    a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_in.busy |=> state_reg == S_SCAN)
        else $error("search launched without entering scan");

    a_hits_le_queries: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= queries_reg)
        else $error("hit count above query count");

endmodule

`default_nettype wire

>>> sv/bcm_cell.sv
// ----------------------------------------------------------------------------
// bcm_cell: one cache entry
// Holds one tag and stamp; updates the passing search packet.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_cell
    import bcm_pkg::*;
#(
    parameter int IDX = 0
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire ctrl_t ctrl,
    input  wire pkt_t  pkt_in,
    output pkt_t       pkt_out
);

    localparam logic [SLOT_W-1:0] ME = SLOT_W'(IDX);

    logic        valid_reg;
    logic [4:0]  disk_reg;
    logic [8:0]  block_reg;
    logic [31:0] stamp_reg;
    pkt_t        pkt_reg;
    pkt_t        pkt_next;
    logic        active;

    assign active  = CNT_W'(IDX) < ctrl.in_use;
    assign pkt_out = pkt_reg;

    always_comb
    begin
        pkt_next = pkt_in;
        if (pkt_in.busy && active)
        begin
            if (!pkt_in.mfound && valid_reg && disk_reg == pkt_in.disk &&
                block_reg == pkt_in.block)
            begin
                pkt_next.mfound = 1'b1;
                pkt_next.midx   = ME;
            end
            if (!pkt_in.vstop)
            begin
                if (!valid_reg)
                begin
                    pkt_next.vidx   = ME;
                    pkt_next.vfound = 1'b1;
                    pkt_next.vstop  = 1'b1;
                end
                else if (!pkt_in.vfound || stamp_reg > pkt_in.best)
                begin
                    pkt_next.best   = stamp_reg;
                    pkt_next.vidx   = ME;
                    pkt_next.vfound = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            disk_reg  <= '0;
            block_reg <= '0;
            stamp_reg <= '0;
            pkt_reg   <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
            if (ctrl.clear)
            begin
                valid_reg <= 1'b0;
                disk_reg  <= '0;
                block_reg <= '0;
                stamp_reg <= '0;
            end
            else
            begin
                if (ctrl.trim && !active)
                begin
                    valid_reg <= 1'b0;
                end
                if (ctrl.wr && ctrl.wr_slot == ME)
                begin
                    stamp_reg <= ctrl.wr_stamp;
                    if (ctrl.wr_tag)
                    begin
                        valid_reg <= 1'b1;
                        disk_reg  <= ctrl.wr_disk;
                        block_reg <= ctrl.wr_block;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/bcm_chain.sv
// ----------------------------------------------------------------------------
// bcm_chain: row of entry cells
// The search packet moves one cell per cycle from first to last entry.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_chain
    import bcm_pkg::*;
#(
    parameter int ENTRIES = 256
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire ctrl_t ctrl,
    input  wire pkt_t  pkt_in,
    output pkt_t       pkt_out
);

    pkt_t link [ENTRIES+1];

    assign link[0] = pkt_in;
    assign pkt_out = link[ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        bcm_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .pkt_in  (link[i]),
            .pkt_out (link[i+1])
        );
    end

endmodule

`default_nettype wire
